// ===== hw/rtl/bct_pkg.sv =====
// Package for the binomial coefficient table: widths, status codes,
// microcode encoding and the control program ROM.
// No dependencies; used by every module of the block.
package bct_pkg;

   localparam int MAX_N    = 32;
   localparam int MAX_K    = MAX_N / 2;
   localparam int N_W      = 6;
   localparam int K_W      = 6;
   localparam int COEF_W   = 31;
   localparam int STATUS_W = 2;
   localparam int FOLD_W   = $clog2(MAX_K + 1);
   localparam int ROW_W    = $clog2(MAX_K);
   localparam int COL_W    = $clog2(MAX_N - 1);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int STEP_W   = 4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_DECODE = 4'd1;
   localparam step_type STEP_TRIV   = 4'd2;
   localparam step_type STEP_COVER  = 4'd3;
   localparam step_type STEP_FRD    = 4'd4;
   localparam step_type STEP_FWR    = 4'd5;
   localparam step_type STEP_LOOK   = 4'd6;
   localparam step_type STEP_OUT    = 4'd7;
   localparam step_type STEP_ONE    = 4'd8;
   localparam step_type STEP_BAD    = 4'd9;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_INIT_FILL,
      OP_FILL_READ,
      OP_FILL_WRITE,
      OP_LOOK_READ,
      OP_EMIT_MEM,
      OP_EMIT_ONE,
      OP_EMIT_BAD
   } op_type;

   typedef enum logic [2:0] {
      CD_NEVER,
      CD_ALWAYS,
      CD_NO_START,
      CD_BAD,
      CD_K_ZERO,
      CD_COVERED,
      CD_FILL_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic bad;
      logic k_zero;
      logic covered;
      logic fill_more;
   } flags_type;

   function automatic uword_type ucode_rom(step_type step);
      uword_type w;
      w = '{op: OP_NOP, cond: CD_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:   w = '{op: OP_LOAD,       cond: CD_NO_START,  target: STEP_IDLE};
         STEP_DECODE: w = '{op: OP_NOP,        cond: CD_BAD,       target: STEP_BAD};
         STEP_TRIV:   w = '{op: OP_NOP,        cond: CD_K_ZERO,    target: STEP_ONE};
         STEP_COVER:  w = '{op: OP_INIT_FILL,  cond: CD_COVERED,   target: STEP_LOOK};
         STEP_FRD:    w = '{op: OP_FILL_READ,  cond: CD_NEVER,     target: STEP_IDLE};
         STEP_FWR:    w = '{op: OP_FILL_WRITE, cond: CD_FILL_MORE, target: STEP_FRD};
         STEP_LOOK:   w = '{op: OP_LOOK_READ,  cond: CD_NEVER,     target: STEP_IDLE};
         STEP_OUT:    w = '{op: OP_EMIT_MEM,   cond: CD_ALWAYS,    target: STEP_IDLE};
         STEP_ONE:    w = '{op: OP_EMIT_ONE,   cond: CD_ALWAYS,    target: STEP_IDLE};
         STEP_BAD:    w = '{op: OP_EMIT_BAD,   cond: CD_ALWAYS,    target: STEP_IDLE};
         default:     w = '{op: OP_NOP,        cond: CD_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/binomial_coefficient_table.sv =====
// Binomial coefficient C(n,k) from an on-demand filled Pascal triangle store.
// A range/order error word skips the store, a folded k of zero returns one, and
// any other lookup reads the store, filling it first when it is not covered,
// each entry with one read and one write-back through the store ports.
// A new word is accepted in the strobe cycle. Reset clears the sequencer and
// the fill marks; the store itself is not cleared. Results cannot be stalled.
module binomial_coefficient_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bct_pkg::N_W-1:0]       req_total_n,
   input  logic [bct_pkg::K_W-1:0]       req_choose_k,
   output logic                          rsp_strobe,
   output logic [bct_pkg::COEF_W-1:0]    rsp_coefficient,
   output logic [bct_pkg::STATUS_W-1:0]  rsp_status
);
   import bct_pkg::*;

   uword_type uword;
   flags_type flags;

   bct_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .uword (uword),
      .busy  (busy)
   );

   bct_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .uword           (uword),
      .req_total_n     (req_total_n),
      .req_choose_k    (req_choose_k),
      .flags           (flags),
      .rsp_strobe      (rsp_strobe),
      .rsp_coefficient (rsp_coefficient),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== hw/rtl/bct_seq.sv =====
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on bct_pkg.
module bct_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bct_pkg::flags_type  flags,
   output bct_pkg::uword_type  uword,
   output logic                busy
);
   import bct_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     take_jump;

   assign uword = ucode_rom(step_ff);
   assign busy  = (step_ff != STEP_IDLE);

   always_comb begin
      unique case (uword.cond)
         CD_NEVER:     take_jump = 1'b0;
         CD_ALWAYS:    take_jump = 1'b1;
         CD_NO_START:  take_jump = !start;
         CD_BAD:       take_jump = flags.bad;
         CD_K_ZERO:    take_jump = flags.k_zero;
         CD_COVERED:   take_jump = flags.covered;
         CD_FILL_MORE: take_jump = flags.fill_more;
         default:      take_jump = 1'b1;
      endcase
   end

   always_comb begin
      step_in = take_jump ? uword.target : step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== hw/rtl/bct_datapath.sv =====
// Datapath: request registers, Pascal triangle store with two read ports,
// fill counters, high-water marks and the result register.
// Depends on bct_pkg; driven by control words from bct_seq.
module bct_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bct_pkg::uword_type            uword,
   input  logic [bct_pkg::N_W-1:0]       req_total_n,
   input  logic [bct_pkg::K_W-1:0]       req_choose_k,
   output bct_pkg::flags_type            flags,
   output logic                          rsp_strobe,
   output logic [bct_pkg::COEF_W-1:0]    rsp_coefficient,
   output logic [bct_pkg::STATUS_W-1:0]  rsp_status
);
   import bct_pkg::*;

   // request word
   logic [N_W-1:0]      n_ff;
   logic [FOLD_W-1:0]   kfold_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [N_W-1:0]      diff;
   logic [N_W-1:0]      fold_raw;
   logic [STATUS_W-1:0] status_in;

   // fill state
   logic [N_W-1:0]    filled_cols_ff;
   logic [N_W-1:0]    filled_cols_in;
   logic [FOLD_W-1:0] filled_rows_ff;
   logic [FOLD_W-1:0] filled_rows_in;
   logic [FOLD_W-1:0] r_ff;
   logic [FOLD_W-1:0] r_in;
   logic [N_W-1:0]    m_ff;
   logic [N_W-1:0]    m_in;
   logic [N_W-1:0]    r_ext;
   logic              row_end;

   // store
   logic [COEF_W-1:0] store_mem [STORE_DEPTH];
   logic [COEF_W-1:0] rd_a_ff;
   logic [COEF_W-1:0] rd_b_ff;
   logic [ADDR_W-1:0] addr_a;
   logic [ADDR_W-1:0] addr_b;
   logic [ADDR_W-1:0] addr_wr;
   logic [FOLD_W-1:0] r_less1;
   logic [FOLD_W-1:0] r_less2;
   logic [FOLD_W-1:0] k_less1;
   logic [N_W-1:0]    col_wr;
   logic [N_W-1:0]    col_a;
   logic [N_W-1:0]    col_look;
   logic              a_is_one;
   logic              b_is_one;
   logic [COEF_W-1:0] opnd_a;
   logic [COEF_W-1:0] opnd_b;
   logic [COEF_W:0]   sum_full;
   logic              rd_en;
   logic              wr_en;

   // result
   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   logic [COEF_W-1:0]   rsp_coefficient_ff;
   logic [COEF_W-1:0]   rsp_coefficient_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;

   // request decode: range check wins over order check
   always_comb begin
      diff     = req_total_n - req_choose_k;
      fold_raw = (diff < req_choose_k) ? diff : req_choose_k;
      if ({1'b0, req_total_n} > (N_W + 1)'(MAX_N)) begin
         status_in = ST_RANGE;
      end else if (req_choose_k > req_total_n) begin
         status_in = ST_ORDER;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (uword.op == OP_LOAD) begin
         n_ff      <= req_total_n;
         kfold_ff  <= fold_raw[FOLD_W-1:0];
         status_ff <= status_in;
      end
   end

   // fill walk: rows r = 1..filled_rows, columns m = r+1..filled_cols
   always_comb begin
      r_ext    = {1'b0, r_ff};
      row_end  = (m_ff == filled_cols_ff);
      r_less1  = r_ff - FOLD_W'(1);
      r_less2  = r_ff - FOLD_W'(2);
      k_less1  = kfold_ff - FOLD_W'(1);
      col_wr   = m_ff - r_ext - N_W'(1);
      col_a    = m_ff - r_ext - N_W'(2);
      col_look = n_ff - {1'b0, kfold_ff} - N_W'(1);
      a_is_one = (m_ff == r_ext + N_W'(1));
      b_is_one = (r_ff == FOLD_W'(1));
      addr_wr  = {r_less1[ROW_W-1:0], col_wr[COL_W-1:0]};
      addr_b   = {r_less2[ROW_W-1:0], col_wr[COL_W-1:0]};
      if (uword.op == OP_LOOK_READ) begin
         addr_a = {k_less1[ROW_W-1:0], col_look[COL_W-1:0]};
      end else begin
         addr_a = {r_less1[ROW_W-1:0], col_a[COL_W-1:0]};
      end
      opnd_a   = a_is_one ? COEF_W'(1) : rd_a_ff;
      opnd_b   = b_is_one ? COEF_W'(1) : rd_b_ff;
      sum_full = {1'b0, opnd_a} + {1'b0, opnd_b};
      rd_en    = (uword.op == OP_FILL_READ) || (uword.op == OP_LOOK_READ);
      wr_en    = (uword.op == OP_FILL_WRITE);
   end

   always_comb begin
      filled_cols_in = filled_cols_ff;
      filled_rows_in = filled_rows_ff;
      r_in           = r_ff;
      m_in           = m_ff;
      if (uword.op == OP_INIT_FILL) begin
         if (n_ff > filled_cols_ff) begin
            filled_cols_in = n_ff;
         end
         if (kfold_ff > filled_rows_ff) begin
            filled_rows_in = kfold_ff;
         end
         r_in = FOLD_W'(1);
         m_in = N_W'(2);
      end else if (uword.op == OP_FILL_WRITE) begin
         // next row starts on its diagonal neighbor, m = r + 1
         if (row_end) begin
            r_in = r_ff + FOLD_W'(1);
            m_in = r_ext + N_W'(2);
         end else begin
            m_in = m_ff + N_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_cols_ff <= N_W'(1);
         filled_rows_ff <= FOLD_W'(1);
      end else begin
         filled_cols_ff <= filled_cols_in;
         filled_rows_ff <= filled_rows_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      m_ff <= m_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr_wr] <= sum_full[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_mem[addr_a];
         rd_b_ff <= store_mem[addr_b];
      end
   end

   assign flags.bad       = (status_ff != ST_OK);
   assign flags.k_zero    = (kfold_ff == '0);
   assign flags.covered   = (n_ff <= filled_cols_ff) && (kfold_ff <= filled_rows_ff);
   assign flags.fill_more = !(row_end && (r_ff == filled_rows_ff));

   // result word
   always_comb begin
      rsp_strobe_in      = 1'b0;
      rsp_coefficient_in = '0;
      rsp_status_in      = ST_OK;
      unique case (uword.op)
         OP_EMIT_MEM: begin
            rsp_strobe_in      = 1'b1;
            rsp_coefficient_in = rd_a_ff;
         end
         OP_EMIT_ONE: begin
            rsp_strobe_in      = 1'b1;
            rsp_coefficient_in = COEF_W'(1);
         end
         OP_EMIT_BAD: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = status_ff;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coefficient_ff <= rsp_coefficient_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_status      = rsp_status_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != ST_OK) |-> rsp_coefficient_ff == '0)
      else $error("nonzero coefficient on an error word");

   a_fill_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (uword.op == OP_FILL_WRITE) |->
         (r_ff <= filled_rows_ff && m_ff <= filled_cols_ff && r_ext < m_ff))
      else $error("fill walk left the covered rectangle");

endmodule
